FILE: rtl/abcfr_pkg.sv
// ----------------------------------------------------------------------------
// Angle-bracket frame receiver package
// Shared constants and the parser-to-emitter request type.
// ----------------------------------------------------------------------------
package abcfr_pkg;

  localparam int LINE_MAX = 64;
  // Holds a frame length up to LINE_MAX-1 and addresses every line entry
  localparam int LEN_W    = $clog2(LINE_MAX);

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd100;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } emit_req_t;

endpackage

FILE: rtl/abcfr_line_ram.sv
// ----------------------------------------------------------------------------
// Line buffer RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module abcfr_line_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/abcfr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame phase, length and idle time, writes frame bytes into the
// line buffer and requests readout on a line feed after '>'.
// ----------------------------------------------------------------------------
module abcfr_parser
  import abcfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             opcode,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  logic             busy,
  output logic             wr_en,
  output logic [LEN_W-1:0] wr_addr,
  output logic [7:0]       wr_data,
  output emit_req_t        req
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_FRAME  = 2'd1;
  localparam logic [1:0] PH_WAITLF = 2'd2;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX - 1);

  logic [1:0]       phase, phase_next;
  logic [LEN_W-1:0] len, len_next;
  logic [15:0]      idle_count, idle_count_next;
  logic [15:0]      idle_timeout;
  logic [15:0]      idle_inc;
  logic             take;

  assign in_ready = !busy;
  assign take     = in_valid && in_ready;
  assign idle_inc = (idle_count == 16'hFFFF) ? idle_count : idle_count + 16'd1;

  always_comb begin
    phase_next      = phase;
    len_next        = len;
    idle_count_next = idle_count;
    wr_en           = 1'b0;
    wr_addr         = len;
    wr_data         = rx_byte;
    req.start       = 1'b0;
    req.len         = len;
    if (take && opcode == OP_TICK) begin
      idle_count_next = idle_inc;
      if (phase != PH_START && idle_inc >= idle_timeout) begin
        phase_next = PH_START;
        len_next   = '0;
      end
    end else if (take) begin
      idle_count_next = '0;
      if (rx_byte == CH_OPEN) begin
        // restart the frame in every phase
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = CH_OPEN;
        len_next   = LEN_W'(1);
        phase_next = PH_FRAME;
      end else begin
        case (phase)
          PH_START: begin
          end
          PH_FRAME: begin
            if (rx_byte inside {CH_CR, CH_LF}) begin
              phase_next = PH_START;
              len_next   = '0;
            end else if (len < LEN_LIMIT) begin
              wr_en    = 1'b1;
              len_next = len + LEN_W'(1);
              if (rx_byte == CH_CLOSE) begin
                phase_next = PH_WAITLF;
              end
            end else begin
              phase_next = PH_START;
              len_next   = '0;
            end
          end
          PH_WAITLF: begin
            if (rx_byte == CH_LF) begin
              // frames at the length limit are dropped without output
              req.start  = (len < LEN_LIMIT) && (len != '0);
              phase_next = PH_START;
              len_next   = '0;
            end else if (rx_byte != CH_CR) begin
              phase_next = PH_START;
              len_next   = '0;
            end
          end
          default: begin
            phase_next = PH_START;
            len_next   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      len          <= '0;
      idle_count   <= '0;
      idle_timeout <= IDLE_TIMEOUT_RESET;
    end else begin
      phase      <= phase_next;
      len        <= len_next;
      idle_count <= idle_count_next;
      if (cfg_we) begin
        idle_timeout <= cfg_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_START) |-> (len == '0))
    else $error("parser idle with nonzero frame length");
  a_waitlf_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WAITLF) |-> (len >= LEN_W'(2)))
    else $error("closed frame shorter than two bytes");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !busy)
    else $error("line buffer written during readout");
`endif

endmodule

FILE: rtl/abcfr_emitter.sv
// ----------------------------------------------------------------------------
// Frame emitter
// Walks the line buffer through its registered read port and drives the
// output register, one frame byte per transfer.
// ----------------------------------------------------------------------------
module abcfr_emitter
  import abcfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  emit_req_t        req,
  output logic             busy,
  output logic             rd_en,
  output logic [LEN_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_data,
  output logic             out_last
);

  logic             active;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] len;
  logic             pend;
  logic             pend_last;
  logic             issue_last;

  assign busy       = active;
  // one read in flight; issue only when the output register will be free
  assign rd_en      = active && !pend && (!out_valid || out_ready);
  assign rd_addr    = idx;
  assign issue_last = (idx == len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.start) begin
        active <= 1'b1;
      end else if (rd_en && issue_last) begin
        active <= 1'b0;
      end
      pend <= rd_en;
      if (pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      idx <= '0;
      len <= req.len;
    end else if (rd_en) begin
      idx <= idx + LEN_W'(1);
    end
    if (rd_en) begin
      pend_last <= issue_last;
    end
    if (pend) begin
      out_data <= rd_data;
      out_last <= pend_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    pend |-> !out_valid)
    else $error("read data returned into a full output register");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !active)
    else $error("readout requested while a frame is still being read");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx < len))
    else $error("readout index beyond frame length");
`endif

endmodule

FILE: rtl/angle_bracket_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// Angle-bracket command frame receiver
// Collects "<...>" frames from a received byte stream into a line buffer and
// plays each completed frame back byte by byte.
// ----------------------------------------------------------------------------
// Each input transfer is a byte or a millisecond tick. When a line feed
// completes a frame, input is held off while the frame is read out of the
// line buffer, one byte at a time through the buffer's registered read port
// and the output register, which the sink may stall. Input resumes once the
// last read is issued, while the last byte may still sit in the output
// register. No clearing pass after reset. The idle timeout register is
// written through the cfg channel, which is always ready.
module angle_bracket_command_frame_receiver
  import abcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] line_byte
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  emit_req_t        req;
  logic             busy;
  logic             wr_en;
  logic [LEN_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [LEN_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign cfg_ready = 1'b1;

  abcfr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .opcode   (s_axis_tuser),
    .rx_byte  (s_axis_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .req      (req)
  );

  abcfr_line_ram #(
    .DEPTH (LINE_MAX),
    .WIDTH (8)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  abcfr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Angle-bracket command frame receiver testbench
// Streams received bytes and millisecond ticks into the receiver, predicts
// the frames it should play back, and checks each output transfer in order.
// Runs a directed table first, then random frame traffic under several idle
// timeouts and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb
  import abcfr_pkg::*;
();

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 5;
  localparam int RANDOM_ITEMS  = 68;

  typedef enum logic [1:0] {SEEK_OPEN, IN_FRAME, AWAIT_LF, PHASE_UNUSED} scan_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_result_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    int         known_count;  // -1: rely on the predictor alone
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = OP_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  // predictor state
  scan_phase_t  scan_phase = SEEK_OPEN;
  logic [7:0]   line_buf [LINE_MAX];
  int           line_len = 0;
  logic [15:0]  idle_ms = 16'd0;
  logic [15:0]  idle_limit = IDLE_TIMEOUT_RESET;
  line_result_t frame_bytes_due [$];

  int           err_count = 0;
  int           items_sent = 0;
  int           quiet_cycles = 0;
  int           send_pct = 23;
  int           recv_pct = 55;
  line_result_t got_due;

  logic [7:0] marker_bytes [4] = '{CH_OPEN, CH_CLOSE, CH_CR, CH_LF};
  logic [15:0] limit_per_phase [PHASES] = '{IDLE_TIMEOUT_RESET, 16'd1, 16'd0, 16'd5, 16'hFFFF};
  int          mode_per_phase [PHASES] = '{0, 0, 1, 1, 2};

  stim_row_t directed_rows [28] = '{
    '{OP_TICK, 8'h00,    0},  // tick right after reset
    '{OP_BYTE, 8'hFF,    0},  // stray bytes while seeking the start
    '{OP_BYTE, CH_CLOSE, 0},
    '{OP_BYTE, CH_LF,    0},
    '{OP_BYTE, CH_OPEN,  0},
    '{OP_BYTE, 8'h00,   -1},
    '{OP_BYTE, 8'hFF,   -1},
    '{OP_BYTE, CH_CLOSE,-1},
    '{OP_BYTE, CH_CR,    0},  // CR after the close is ignored
    '{OP_BYTE, CH_LF,    4},
    '{OP_BYTE, CH_OPEN, -1},
    '{OP_BYTE, 8'h41,   -1},
    '{OP_BYTE, CH_OPEN, -1},  // restart inside a frame
    '{OP_BYTE, 8'h42,   -1},
    '{OP_BYTE, CH_CLOSE,-1},
    '{OP_BYTE, CH_OPEN, -1},  // restart while waiting for the line feed
    '{OP_BYTE, CH_CLOSE,-1},
    '{OP_BYTE, CH_LF,    2},
    '{OP_BYTE, CH_OPEN, -1},
    '{OP_BYTE, 8'h43,   -1},
    '{OP_BYTE, CH_CR,    0},  // CR inside a frame drops it
    '{OP_BYTE, CH_OPEN,  0},
    '{OP_BYTE, CH_LF,    0},  // LF inside a frame drops it
    '{OP_BYTE, CH_OPEN,  0},
    '{OP_BYTE, CH_CLOSE, 0},
    '{OP_BYTE, 8'h78,    0},  // other byte after the close drops it
    '{OP_BYTE, CH_LF,    0},
    '{OP_TICK, CH_OPEN,  0}   // tick data is ignored
  };

  angle_bracket_command_frame_receiver DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void discard_line();
    scan_phase = SEEK_OPEN;
    line_len   = 0;
  endfunction

  // Advance the predictor by one input transfer; queue the frame bytes it emits.
  function automatic int predict_line_output(input logic op, input logic [7:0] b);
    int produced;
    line_result_t r;
    produced = 0;
    if (op == OP_TICK) begin
      if (idle_ms != 16'hFFFF) idle_ms++;
      if (scan_phase != SEEK_OPEN && idle_ms >= idle_limit) discard_line();
      return 0;
    end
    idle_ms = 16'd0;
    if (b == CH_OPEN) begin
      line_buf[0] = CH_OPEN;
      line_len    = 1;
      scan_phase  = IN_FRAME;
      return 0;
    end
    case (scan_phase)
      SEEK_OPEN: ;
      IN_FRAME: begin
        if (b == CH_CR || b == CH_LF) begin
          discard_line();
        end else if (line_len < LINE_MAX - 1) begin
          line_buf[line_len] = b;
          line_len++;
          if (b == CH_CLOSE) scan_phase = AWAIT_LF;
        end else begin
          discard_line();
        end
      end
      AWAIT_LF: begin
        if (b == CH_LF) begin
          // frames of LINE_MAX-1 bytes or more are dropped silently
          if (line_len != 0 && line_len < LINE_MAX - 1) begin
            for (int i = 0; i < line_len; i++) begin
              r.data = line_buf[i];
              r.last = (i == line_len - 1);
              frame_bytes_due.push_back(r);
            end
            produced = line_len;
          end
          discard_line();
        end else if (b != CH_CR) begin
          discard_line();
        end
      end
      default: discard_line();
    endcase
    return produced;
  endfunction

  function automatic logic sender_idles();
    return $urandom_range(0, 99) < send_pct;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_OPEN || b == CH_CLOSE || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] noisy_byte();
    if ($urandom_range(0, 2) == 0) return marker_bytes[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, output int produced);
    if (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (sender_idles());
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    produced = predict_line_output(op, b);
    items_sent++;
  endtask

  task automatic feed(input logic op, input logic [7:0] b);
    int unused;
    send_item(op, b, unused);
  endtask

  // Hold off input until every queued frame byte has been taken, then settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    idle_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame_sequence();
    int kind;
    int payload_len;
    int burst;
    logic broken;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) feed(1'($urandom_range(0, 1)), noisy_byte());
      return;
    end
    broken = (kind < 32);
    // mostly short frames; a few hit the long-frame and overflow limits
    payload_len = ($urandom_range(0, 7) == 0) ? $urandom_range(LINE_MAX - 8, LINE_MAX - 1)
                                              : $urandom_range(0, 10);
    feed(OP_BYTE, CH_OPEN);
    for (int i = 0; i < payload_len; i++) begin
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) feed(OP_TICK, 8'($urandom));
      feed(OP_BYTE, plain_byte());
    end
    if (idle_limit <= 16'd120 && $urandom_range(0, 5) == 0) begin
      burst = int'(idle_limit) + $urandom_range(0, 2) - 1;
      repeat (burst) feed(OP_TICK, 8'($urandom));
    end
    if (broken && $urandom_range(0, 1) == 0) feed(OP_BYTE, noisy_byte());
    feed(OP_BYTE, CH_CLOSE);
    if (broken && $urandom_range(0, 1) == 0) feed(OP_BYTE, noisy_byte());
    if ($urandom_range(0, 3) == 0) feed(OP_BYTE, CH_CR);
    feed(OP_BYTE, CH_LF);
    if ($urandom_range(0, 9) == 0) drain_results();
  endtask

  always @(posedge clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected line byte %02h last %0b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        got_due = frame_bytes_due.pop_front();
        if (m_axis_tdata !== got_due.data)
          report_mismatch($sformatf("line_byte %02h, want %02h", m_axis_tdata, got_due.data));
        if (m_axis_tlast !== got_due.last)
          report_mismatch($sformatf("line_last %0b, want %0b", m_axis_tlast, got_due.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int produced;
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        write_idle_limit(limit_per_phase[p]);
      end
      case (mode_per_phase[p])
        0:       begin send_pct = 23; recv_pct = 55; end
        1:       begin send_pct = 55; recv_pct = 23; end
        default: begin send_pct = 0;  recv_pct = 0;  end
      endcase
      if (p == 0) begin
        foreach (directed_rows[i]) begin
          send_item(directed_rows[i].op, directed_rows[i].data, produced);
          if (directed_rows[i].known_count >= 0 && produced != directed_rows[i].known_count)
            report_mismatch($sformatf("row %0d: %0d frame bytes predicted, table says %0d",
                                      i, produced, directed_rows[i].known_count));
        end
        drain_results();
      end
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) run_frame_sequence();
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0 && frame_bytes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/abcfr_pkg.sv
rtl/abcfr_line_ram.sv
rtl/abcfr_parser.sv
rtl/abcfr_emitter.sv
rtl/angle_bracket_command_frame_receiver.sv
verif/tb.sv
